### src/fss_pkg.sv
// Shared types, constants and codes for the fuzzy subsequence scorer.
`timescale 1ns / 1ps

package fss_pkg;

  // Sizing of the query store and the text length counter.
  localparam int MAX_QUERY_CHARS = 32;
  localparam int MAX_TEXT_LENGTH = 4096;
  localparam int QPOS_W = $clog2(MAX_QUERY_CHARS + 1);
  localparam int QIDX_W = $clog2(MAX_QUERY_CHARS);
  localparam int TPOS_W = $clog2(MAX_TEXT_LENGTH);
  localparam int QUERY_BITS = MAX_QUERY_CHARS * 8;
  localparam int RUN_W = QPOS_W;
  localparam int SCORE_W = 12;
  localparam int RESULT_W = 13;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int CHARS_PER_WORD = CFG_DATA_W / 8;
  localparam int QUERY_WORDS = MAX_QUERY_CHARS / CHARS_PER_WORD;

  // Division by ten through a reciprocal multiply; exact for 12-bit lengths.
  localparam int DIV10_MUL = 6554;
  localparam int DIV10_SHIFT = 16;
  localparam int PROD_W = TPOS_W + 13;
  localparam int QUOT_W = PROD_W - DIV10_SHIFT;

  // Scoring weights.
  localparam logic [SCORE_W-1:0] BOUNDARY_BONUS = SCORE_W'(10);
  localparam logic [SCORE_W-1:0] FIRST_POS_BONUS = SCORE_W'(6);

  // Characters that matter to the boundary test.
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_QUERY_LENGTH  = 3'd0,
    CFG_QUERY_CHARS_0 = 3'd1,
    CFG_QUERY_CHARS_1 = 3'd2,
    CFG_QUERY_CHARS_2 = 3'd3,
    CFG_QUERY_CHARS_3 = 3'd4
  } cfg_index_t;

  // Input beat.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } text_item_t;

  // Output beat.
  typedef struct packed {
    logic signed [RESULT_W-1:0] match_score;
    logic                       matched;
  } score_item_t;

  // Per-text scoring state.
  typedef struct packed {
    logic [TPOS_W-1:0]  text_position;
    logic [QPOS_W-1:0]  query_position;
    logic [RUN_W-1:0]   run_length;
    logic [SCORE_W-1:0] running_score;
    logic [7:0]         previous_byte;
  } fss_state_t;

  localparam fss_state_t STATE_RESET = '{
    text_position:  '0,
    query_position: '0,
    run_length:     '0,
    running_score:  '0,
    previous_byte:  CHAR_SLASH
  };

  // Snapshot of a finished text, handed to the result stage.
  typedef struct packed {
    logic               empty_query;
    logic               complete;
    logic [SCORE_W-1:0] score;
    logic [TPOS_W-1:0]  text_len;
  } fss_summary_t;

endpackage

### src/fss_step.sv
// Next-state logic for one text byte: lowercase, compare, boundary test, score add.
`timescale 1ns / 1ps

module fss_step
  import fss_pkg::*;
(
  input  fss_state_t             state,
  input  text_item_t             item,
  input  logic [QPOS_W-1:0]      query_length,
  input  logic [QUERY_BITS-1:0]  query_flat,
  output fss_state_t             state_next,
  output fss_summary_t           summary
);

  logic [QPOS_W-1:0]  active_len;
  logic [7:0]         lower_byte;
  logic [7:0]         query_char;
  logic [QIDX_W-1:0]  query_idx;
  logic               prev_is_sep;
  logic               case_step;
  logic               boundary;
  logic [SCORE_W-1:0] gain;

  // Clamp the query length to the size of the query store.
  assign active_len = (query_length > QPOS_W'(MAX_QUERY_CHARS)) ?
                      QPOS_W'(MAX_QUERY_CHARS) : query_length;

  // ASCII lowercase of the incoming byte.
  assign lower_byte = (item.text_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ?
                      item.text_byte + CASE_OFFSET : item.text_byte;

  // Next query character to match.
  assign query_idx  = state.query_position[QIDX_W-1:0];
  assign query_char = query_flat[{query_idx, 3'b000} +: 8];

  // Word boundary: after a separator, or a lower-to-upper case step.
  assign prev_is_sep = state.previous_byte inside
                       {CHAR_SLASH, CHAR_UNDERSCORE, CHAR_DASH, CHAR_DOT, CHAR_SPACE};
  assign case_step   = (state.previous_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) &&
                       (item.text_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]});
  assign boundary    = prev_is_sep || case_step;

  // Score gained by a match at this byte.
  assign gain = SCORE_W'(1) + SCORE_W'({state.run_length, 2'b00}) +
                (boundary ? BOUNDARY_BONUS : '0) +
                ((state.text_position == '0) ? FIRST_POS_BONUS : '0);

  // State update for a present byte.
  always_comb begin
    state_next = state;
    if (item.byte_present) begin
      if (state.query_position < active_len) begin
        if (lower_byte == query_char) begin
          state_next.running_score  = state.running_score + gain;
          state_next.run_length     = state.run_length + RUN_W'(1);
          state_next.query_position = state.query_position + QPOS_W'(1);
        end else begin
          state_next.run_length = '0;
        end
      end
      state_next.previous_byte = item.text_byte;
      if (state.text_position != {TPOS_W{1'b1}}) begin
        state_next.text_position = state.text_position + TPOS_W'(1);
      end
    end
  end

  // What the result stage needs if this is the final byte.
  assign summary.empty_query = (active_len == '0);
  assign summary.complete    = (state_next.query_position >= active_len);
  assign summary.score       = state_next.running_score;
  assign summary.text_len    = state_next.text_position;

endmodule

### src/fuzzy_subsequence_scorer_core.sv
// Top level: query registers, per-text state, and the two-stage result pipeline.
// Throughput: one text byte per cycle while text_stall is low; the state update is registered.
// Result path: the final byte's summary is registered in the snapshot stage, then the
// divide-by-ten multiply and subtract feed the output register once it is free.
// Reset: rst clears the query registers to zero, the text state to its start
// values (previous byte '/'), and both pipeline stages to empty.
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_core
  import fss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  text_item_t             text_item,
  output logic                   score_valid,
  input  logic                   score_stall,
  output score_item_t            score_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [QPOS_W-1:0]     query_length;
  logic [CFG_DATA_W-1:0] query_chars [QUERY_WORDS];
  logic [QUERY_BITS-1:0] query_flat;

  fss_state_t   state;
  fss_state_t   state_next;
  fss_summary_t summary;

  fss_summary_t s1;
  logic         s1_valid;
  logic         s1_advance;
  logic         text_accept;

  logic [PROD_W-1:0]          product;
  logic [QUOT_W-1:0]          quotient;
  logic signed [RESULT_W-1:0] final_score;
  score_item_t                result;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      for (int i = 0; i < QUERY_WORDS; i++) begin
        query_chars[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_QUERY_LENGTH:  query_length   <= cfg_data[QPOS_W-1:0];
        CFG_QUERY_CHARS_0: query_chars[0] <= cfg_data;
        CFG_QUERY_CHARS_1: query_chars[1] <= cfg_data;
        CFG_QUERY_CHARS_2: query_chars[2] <= cfg_data;
        CFG_QUERY_CHARS_3: query_chars[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Character 0 sits in the low byte of the first word.
  always_comb begin
    for (int i = 0; i < QUERY_WORDS; i++) begin
      query_flat[i*CFG_DATA_W +: CFG_DATA_W] = query_chars[i];
    end
  end

  // Handshake: the snapshot stage moves on when the output register is free.
  assign s1_advance  = s1_valid && (!score_valid || !score_stall);
  assign text_stall  = s1_valid && !s1_advance;
  assign text_accept = text_valid && !text_stall;

  fss_step u_step (
    .state        (state),
    .item         (text_item),
    .query_length (query_length),
    .query_flat   (query_flat),
    .state_next   (state_next),
    .summary      (summary)
  );

  // Per-text state; the final byte returns it to the start values.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (text_accept) begin
      state <= text_item.end_of_text ? STATE_RESET : state_next;
    end
  end

  // Snapshot stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_accept && text_item.end_of_text) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept && text_item.end_of_text) begin
      s1 <= summary;
    end
  end

  // Length penalty: length / 10 by reciprocal multiply.
  assign product  = PROD_W'(s1.text_len) * PROD_W'(DIV10_MUL);
  assign quotient = product[PROD_W-1:DIV10_SHIFT];
  assign final_score = $signed(RESULT_W'({1'b0, s1.score})) -
                       $signed(RESULT_W'(quotient));

  // Result selection: empty query, incomplete match, or scored match.
  always_comb begin
    if (s1.empty_query) begin
      result.match_score = '0;
      result.matched     = 1'b1;
    end else if (!s1.complete) begin
      result.match_score = '1;
      result.matched     = 1'b0;
    end else begin
      result.match_score = final_score;
      result.matched     = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
    end else if (s1_advance) begin
      score_valid <= 1'b1;
    end else if (!score_stall) begin
      score_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      score_item <= result;
    end
  end

  // An unmatched result always carries minus one.
  a_unmatched_score: assert property (@(posedge clk) disable iff (rst)
    score_valid && !score_item.matched |-> score_item.match_score == '1)
    else $error("unmatched result without minus one score");

  // The final byte leaves the text state at its start values.
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    text_accept && text_item.end_of_text |=>
      state.text_position == '0 && state.query_position == '0 &&
      state.running_score == '0 && state.run_length == '0)
    else $error("text state not cleared after final byte");

  // A held snapshot is never dropped.
  a_snapshot_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid)
    else $error("snapshot lost while output was stalled");

  // The query position never runs past the store.
  a_qpos_bound: assert property (@(posedge clk) disable iff (rst)
    state.query_position <= QPOS_W'(MAX_QUERY_CHARS))
    else $error("query position beyond query store");

endmodule

### sim/fss_score_checker.sv
// Score checker for the fuzzy subsequence scorer: predicts every text's score and checks result beats.
`timescale 1ns / 1ps

module fss_score_checker
  import fss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  input  logic                   text_stall,
  input  text_item_t             text_item,
  input  logic                   score_valid,
  input  logic                   score_stall,
  input  score_item_t            score_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     texts_scored,
  output int                     texts_matched
);

  localparam int STREAK_WEIGHT = 4;
  localparam int LENGTH_DIVISOR = 10;

  // Shadow copy of the query registers.
  logic [QPOS_W-1:0]     query_len;
  logic [CFG_DATA_W-1:0] query_words [QUERY_WORDS];

  // Per-text scoring state.
  int         text_len;
  int         query_pos;
  int         streak;
  int         score_sum;
  logic [7:0] prev_char;

  // Scores still owed by the block, oldest first.
  score_item_t expected_scores [$];

  int fail_total = 0;
  int scored_total = 0;
  int matched_total = 0;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  // A word starts after a separator or where lowercase turns to uppercase.
  function automatic bit at_boundary(logic [7:0] prev, logic [7:0] cur);
    return prev == CHAR_SLASH || prev == CHAR_UNDERSCORE || prev == CHAR_DASH ||
           prev == CHAR_DOT || prev == CHAR_SPACE ||
           (prev >= CHAR_LOWER_A && prev <= CHAR_LOWER_Z &&
            cur >= CHAR_UPPER_A && cur <= CHAR_UPPER_Z);
  endfunction

  function automatic logic [7:0] query_char_at(int idx);
    return query_words[idx / CHARS_PER_WORD][(idx % CHARS_PER_WORD) * 8 +: 8];
  endfunction

  task automatic restart_text();
    text_len = 0;
    query_pos = 0;
    streak = 0;
    score_sum = 0;
    prev_char = CHAR_SLASH;
  endtask

  // Advance the scoring state by one text beat and queue the score at the end of a text.
  task automatic score_beat(input text_item_t beat);
    int          active;
    score_item_t want;
    active = (query_len > MAX_QUERY_CHARS) ? MAX_QUERY_CHARS : int'(query_len);
    if (beat.byte_present) begin
      if (query_pos < active) begin
        if (fold_case(beat.text_byte) == query_char_at(query_pos)) begin
          score_sum += 1 + STREAK_WEIGHT * streak;
          if (at_boundary(prev_char, beat.text_byte)) score_sum += int'(BOUNDARY_BONUS);
          if (text_len == 0) score_sum += int'(FIRST_POS_BONUS);
          streak++;
          query_pos++;
        end else begin
          streak = 0;
        end
      end
      prev_char = beat.text_byte;
      if (text_len < MAX_TEXT_LENGTH - 1) text_len++;
    end
    if (beat.end_of_text) begin
      if (active == 0) begin
        want.match_score = '0;
        want.matched = 1'b1;
      end else if (query_pos < active) begin
        want.match_score = RESULT_W'(-1);
        want.matched = 1'b0;
      end else begin
        want.match_score = RESULT_W'(score_sum - text_len / LENGTH_DIVISOR);
        want.matched = 1'b1;
      end
      expected_scores.push_back(want);
      restart_text();
    end
  endtask

  // Compare one result beat against the oldest owed score.
  task automatic check_result(input score_item_t got);
    score_item_t want;
    if (expected_scores.size() == 0) begin
      $error("unexpected score beat: match_score %0d, matched %0b",
             got.match_score, got.matched);
      fail_total++;
    end else begin
      want = expected_scores.pop_front();
      scored_total++;
      if (want.matched) matched_total++;
      if (got.match_score !== want.match_score) begin
        $error("match_score: expected %0d, got %0d", want.match_score, got.match_score);
        fail_total++;
      end
      if (got.matched !== want.matched) begin
        $error("matched: expected %0b, got %0b", want.matched, got.matched);
        fail_total++;
      end
    end
  endtask

  // Everything is sampled at the edge where the block itself sees it.
  always @(posedge clk) begin
    if (rst) begin
      query_len = '0;
      foreach (query_words[w]) query_words[w] = '0;
      restart_text();
      expected_scores.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_QUERY_LENGTH: query_len = cfg_data[QPOS_W-1:0];
          CFG_QUERY_CHARS_0, CFG_QUERY_CHARS_1, CFG_QUERY_CHARS_2, CFG_QUERY_CHARS_3:
            query_words[cfg_index - CFG_QUERY_CHARS_0] = cfg_data;
          default: ;
        endcase
      end
      if (score_valid && !score_stall) check_result(score_item);
      if (text_valid && !text_stall) score_beat(text_item);
    end
    mismatches <= fail_total;
    outstanding <= expected_scores.size();
    texts_scored <= scored_total;
    texts_matched <= matched_total;
  end

endmodule

### sim/fuzzy_subsequence_scorer_core_test.sv
// Testbench top for the fuzzy subsequence scorer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_core_test;
  import fss_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef enum int {FLOW_SLOW_SINK, FLOW_SLOW_SOURCE, FLOW_FREE} flow_mode_t;
  typedef enum int {SETUP_EMPTY, SETUP_FULL, SETUP_OVERSIZED, SETUP_SHORT} query_setup_t;
  typedef enum int {FILL_ONES, FILL_ZEROS, FILL_MIXED} query_fill_t;
  typedef enum int {TEXT_WELL_FORMED, TEXT_BROKEN, TEXT_NOISE} text_kind_t;

  localparam int FLOW_MODES = 3;
  localparam int SETUPS_PER_MODE = 4;
  localparam int BEATS_PER_SETUP = 117;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [7:0] CHAR_ZERO = "0";

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   text_valid = 1'b0;
  logic                   text_stall;
  text_item_t             text_item = '0;
  logic                   score_valid;
  logic                   score_stall = 1'b0;
  score_item_t            score_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int beats_sent = 0;

  // Stimulus-side copy of the programmed query, used to build matching texts.
  logic [7:0]        query_bytes [MAX_QUERY_CHARS];
  logic [QPOS_W-1:0] query_len_field = '0;

  int mismatches;
  int outstanding;
  int texts_scored;
  int texts_matched;

  fuzzy_subsequence_scorer_core dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .score_valid (score_valid),
    .score_stall (score_stall),
    .score_item  (score_item),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  fss_score_checker score_checker (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text_item     (text_item),
    .score_valid   (score_valid),
    .score_stall   (score_stall),
    .score_item    (score_item),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .texts_scored  (texts_scored),
    .texts_matched (texts_matched)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The score receiver stalls at random.
  always @(posedge clk) begin
    score_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic int active_query_len();
    return (query_len_field > MAX_QUERY_CHARS) ? MAX_QUERY_CHARS : int'(query_len_field);
  endfunction

  function automatic logic [7:0] separator_char();
    case ($urandom_range(4))
      0: return CHAR_SLASH;
      1: return CHAR_UNDERSCORE;
      2: return CHAR_DASH;
      3: return CHAR_DOT;
      default: return CHAR_SPACE;
    endcase
  endfunction

  // Filler bytes lean toward separators and letters so boundaries come up often.
  function automatic logic [7:0] filler_char();
    case ($urandom_range(9))
      0, 1, 2: return separator_char();
      3, 4, 5: return CHAR_LOWER_A + 8'($urandom_range(25));
      6, 7: return CHAR_UPPER_A + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_query_char(int upper_pct);
    if ($urandom_range(99) < upper_pct) return CHAR_UPPER_A + 8'($urandom_range(25));
    case ($urandom_range(7))
      0: return separator_char();
      1: return CHAR_ZERO + 8'($urandom_range(9));
      default: return CHAR_LOWER_A + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // A well-formed text holds the query as a subsequence; a broken one drops one query character.
  function automatic byte_q_t build_text(text_kind_t kind);
    byte_q_t    t;
    int         active;
    int         skip;
    logic [7:0] c;
    active = active_query_len();
    if (kind == TEXT_NOISE) begin
      repeat ($urandom_range(30)) t.push_back(filler_char());
      return t;
    end
    skip = (kind == TEXT_BROKEN && active > 0) ? $urandom_range(active - 1) : -1;
    for (int k = 0; k < active; k++) begin
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(3, 1)) t.push_back(filler_char());
      end
      if (k != skip) begin
        c = query_bytes[k];
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(1) == 1) c -= CASE_OFFSET;
        t.push_back(c);
      end
    end
    repeat ($urandom_range(3)) t.push_back(filler_char());
    return t;
  endfunction

  function automatic text_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 70) return TEXT_WELL_FORMED;
    if (r < 85) return TEXT_BROKEN;
    return TEXT_NOISE;
  endfunction

  task automatic set_flow(input flow_mode_t flow);
    case (flow)
      FLOW_SLOW_SINK: begin
        sender_idle_pct = 19;
        receiver_stall_pct <= 77;
      end
      FLOW_SLOW_SOURCE: begin
        sender_idle_pct = 77;
        receiver_stall_pct <= 19;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
      end
    endcase
  endtask

  // Offer one text beat, with random gaps before it, and hold it until accepted.
  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item <= '{text_byte: b, byte_present: present, end_of_text: last};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    if (present || last) beats_sent++;
  endtask

  // Stream a text; an empty text, or one closed by an empty beat, ends with byte_present low.
  task automatic send_text(input byte_q_t t, input bit empty_tail);
    for (int i = 0; i < t.size(); i++) begin
      if ($urandom_range(99) < 4) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(t[i], 1'b1, (i == t.size() - 1) && !empty_tail);
    end
    if (empty_tail || t.size() == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Wait until every owed score has arrived, then let the pipeline settle.
  task automatic drain();
    int guard;
    guard = 0;
    text_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the length register and all four character words on consecutive cycles.
  task automatic program_query(input logic [QPOS_W-1:0] len);
    logic [CFG_DATA_W-1:0] word;
    query_len_field = len;
    word = {$urandom, $urandom};
    word[QPOS_W-1:0] = len;
    cfg_write <= 1'b1;
    cfg_index <= CFG_QUERY_LENGTH;
    cfg_data <= word;
    @(posedge clk);
    for (int r = 0; r < QUERY_WORDS; r++) begin
      for (int k = 0; k < CHARS_PER_WORD; k++) word[k * 8 +: 8] = query_bytes[r * CHARS_PER_WORD + k];
      cfg_index <= CFG_INDEX_W'(CFG_QUERY_CHARS_0) + CFG_INDEX_W'(r);
      cfg_data <= word;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic load_query_string(input string s);
    for (int k = 0; k < MAX_QUERY_CHARS; k++) query_bytes[k] = (k < s.len()) ? s[k] : 8'h00;
    program_query(QPOS_W'(s.len()));
  endtask

  task automatic configure(input flow_mode_t flow, input query_setup_t setup);
    query_fill_t       fill;
    int                upper_pct;
    logic [QPOS_W-1:0] len;
    fill = FILL_MIXED;
    upper_pct = 0;
    case (setup)
      SETUP_EMPTY: len = '0;
      SETUP_FULL: begin
        len = QPOS_W'(MAX_QUERY_CHARS);
        if (flow == FLOW_SLOW_SINK) fill = FILL_ONES;
        else if (flow == FLOW_SLOW_SOURCE) fill = FILL_ZEROS;
      end
      SETUP_OVERSIZED:
        len = (flow == FLOW_FREE) ? '1 :
              QPOS_W'($urandom_range((1 << QPOS_W) - 1, MAX_QUERY_CHARS + 1));
      default: begin
        len = QPOS_W'($urandom_range(8, 1));
        upper_pct = 8;
      end
    endcase
    for (int k = 0; k < MAX_QUERY_CHARS; k++) begin
      case (fill)
        FILL_ONES: query_bytes[k] = 8'hFF;
        FILL_ZEROS: query_bytes[k] = 8'h00;
        default: query_bytes[k] = pick_query_char(upper_pct);
      endcase
    end
    program_query(len);
  endtask

  initial begin
    byte_q_t t;
    int      budget;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_flow(FLOW_SLOW_SINK);

    // Directed: empty query straight out of reset, including an empty text.
    send_text(to_bytes("a"), 1'b0);
    send_text(to_bytes(""), 1'b1);
    drain();

    // Directed: case folding, streaks, separators, camel-case boundary, misses, byte extremes.
    load_query_string("ab");
    send_text(to_bytes("AB"), 1'b0);
    send_text(to_bytes("xaB"), 1'b0);
    send_text(to_bytes("ba"), 1'b0);
    send_text(to_bytes("_a-b"), 1'b0);
    send_text(to_bytes(".a b"), 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    t = to_bytes("ab");
    t.push_back(8'hFF);
    t.push_back(8'h00);
    send_text(t, 1'b1);
    drain();

    // Directed: an uppercase query byte can never match.
    load_query_string("aB");
    send_text(to_bytes("ab"), 1'b0);
    drain();

    // Random texts under each flow mode and query setup.
    for (int f = 0; f < FLOW_MODES; f++) begin
      set_flow(flow_mode_t'(f));
      for (int s = 0; s < SETUPS_PER_MODE; s++) begin
        configure(flow_mode_t'(f), query_setup_t'(s));
        budget = beats_sent + BEATS_PER_SETUP;
        while (beats_sent < budget) send_text(build_text(pick_kind()), $urandom_range(4) == 0);
        drain();
      end
    end

    if (outstanding != 0) $error("%0d expected scores never arrived", outstanding);
    $display("Checked %0d scored texts (%0d fully matched) from %0d text beats.",
             texts_scored, texts_matched, beats_sent);
    $display("Queries: empty, full, oversized and short, under three flow-control modes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### fuzzy_subsequence_scorer_core.f
src/fss_pkg.sv
src/fss_step.sv
src/fuzzy_subsequence_scorer_core.sv
sim/fss_score_checker.sv
sim/fuzzy_subsequence_scorer_core_test.sv
